[design/tcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Attribute after reset
  localparam logic [7:0] RESET_COLOR = 8'd7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] entry_color;
    logic [6:0] pos_x;
    logic [4:0] pos_y;
  } in_req_t;

  typedef struct packed {
    logic [15:0] cell_data;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } out_res_t;

endpackage

`default_nettype wire

[design/tcw_cell_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [15:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [15:0]   rdata
);

  logic [15:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/tcw_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module tcw_seq #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  parameter int AW   = 11
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire tcw_pkg::in_req_t in_req,
  input  wire logic [7:0]       text_color,
  output logic                  busy,
  output logic                  out_strobe,
  output tcw_pkg::out_res_t     out_res,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [15:0]           ram_wdata,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_raddr,
  input  wire logic [15:0]      ram_rdata
);

  localparam int CELLS = COLS * ROWS;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);

  localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLS - 1);
  localparam logic [AW-1:0]    COLS_A    = AW'(COLS);
  localparam logic [AW-1:0]    LAST_COPY = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [7:0]       COLS_CMP  = 8'(COLS);
  localparam logic [6:0]       ROWS_CMP  = 7'(ROWS);
  localparam logic [ROW_W:0]   ROWS_CHK  = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W:0]   COLS_CHK  = (COL_W + 1)'(COLS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ADDR = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_RDAT = 7'b0001000,
    S_SCRD = 7'b0010000,
    S_SCWR = 7'b0100000,
    S_FILL = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   y_r, y_nxt;
  logic [COL_W-1:0]   x_r, x_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [AW-1:0]      sw_r, sw_nxt;
  logic               init_r, init_nxt;
  tcw_pkg::in_req_t   req_r, req_nxt;
  logic               out_valid_r, out_valid_nxt;
  tcw_pkg::out_res_t  out_res_r, out_res_nxt;

  logic               fin;
  logic [15:0]        fin_data;
  logic               in_range;
  logic [15:0]        blank;

  assign in_range = ({1'b0, in_req.pos_x} < COLS_CMP) && ({2'b00, in_req.pos_y} < ROWS_CMP);
  assign blank    = init_r ? {tcw_pkg::RESET_COLOR, tcw_pkg::CH_SPACE}
                           : {text_color, tcw_pkg::CH_SPACE};

  // Sequencer: address build, cell access and sweeps over the cell store
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    y_nxt     = y_r;
    x_nxt     = x_r;
    addr_nxt  = addr_r;
    sw_nxt    = sw_r;
    init_nxt  = init_r;
    req_nxt   = req_r;
    fin       = 1'b0;
    fin_data  = 16'd0;
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          unique case (in_req.req_type) inside
            tcw_pkg::REQ_PUT: begin
              if (in_req.char_code == tcw_pkg::CH_CR) begin
                fin = 1'b1;
              end else if (in_req.char_code == tcw_pkg::CH_LF) begin
                col_nxt = '0;
                if (row_r == ROW_LAST) begin
                  sw_nxt    = '0;
                  state_nxt = S_SCRD;
                end else begin
                  row_nxt = row_r + 1'b1;
                  fin     = 1'b1;
                end
              end else begin
                y_nxt     = row_r;
                x_nxt     = col_r;
                state_nxt = S_ADDR;
              end
            end
            tcw_pkg::REQ_CLEAR: begin
              sw_nxt    = '0;
              state_nxt = S_FILL;
            end
            tcw_pkg::REQ_WRITE, tcw_pkg::REQ_READ: begin
              if (in_range) begin
                y_nxt     = ROW_W'(in_req.pos_y);
                x_nxt     = COL_W'(in_req.pos_x);
                state_nxt = S_ADDR;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Form the linear cell index
      S_ADDR: begin
        addr_nxt  = AW'(y_r) * COLS_A + AW'(x_r);
        state_nxt = S_ACC;
      end

      // Write the cell, or issue the read
      S_ACC: begin
        if (req_r.req_type == tcw_pkg::REQ_READ) begin
          ram_re    = 1'b1;
          state_nxt = S_RDAT;
        end else begin
          ram_we    = 1'b1;
          if (req_r.req_type == tcw_pkg::REQ_PUT) begin
            ram_wdata = {text_color, req_r.char_code};
            if (col_r == COL_LAST) begin
              col_nxt = '0;
              row_nxt = (row_r == ROW_LAST) ? '0 : row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end else begin
            ram_wdata = {req_r.entry_color, req_r.char_code};
          end
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_RDAT: begin
        fin       = 1'b1;
        fin_data  = ram_rdata;
        state_nxt = S_IDLE;
      end

      // Scroll: fetch the cell one row below
      S_SCRD: begin
        ram_re    = 1'b1;
        ram_raddr = sw_r + COLS_A;
        state_nxt = S_SCWR;
      end

      // Scroll: store it one row up
      S_SCWR: begin
        ram_we    = 1'b1;
        ram_waddr = sw_r;
        ram_wdata = ram_rdata;
        sw_nxt    = sw_r + 1'b1;
        state_nxt = (sw_r == LAST_COPY) ? S_FILL : S_SCRD;
      end

      // Blank cells up to the end of the store
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = sw_r;
        if (sw_r == LAST_CELL) begin
          state_nxt = S_IDLE;
          init_nxt  = 1'b0;
          fin       = !init_r;
        end else begin
          sw_nxt = sw_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = fin;
    out_res_nxt   = {fin_data, 5'(row_nxt), 7'(col_nxt)};
  end

  // Control state; the store is swept blank after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      row_r       <= '0;
      col_r       <= '0;
      sw_r        <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      sw_r        <= sw_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    y_r       <= y_nxt;
    x_r       <= x_nxt;
    addr_r    <= addr_nxt;
    req_r     <= req_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_valid_r;
  assign out_res    = out_res_r;

`ifndef SYNTHESIS
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE) || $past(start))
    else $error("result strobe without a request at work");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_r} < ROWS_CHK)
    else $error("cursor row out of range");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_r} < COLS_CHK)
    else $error("cursor column out of range");

  a_cr_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start && in_req.req_type == tcw_pkg::REQ_PUT
     && in_req.char_code == tcw_pkg::CH_CR) |=> out_valid_r)
    else $error("carriage return gave no result");

  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !out_valid_r)
    else $error("result during the reset clearing pass");
`endif

endmodule

`default_nettype wire

[design/text_console_cursor_writer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Text console engine: a COLS x ROWS store of 16-bit cells (attribute high
// byte, character low byte) plus a cursor.
// Request channel: a request is taken at a rising edge with start high and
// busy low. Result channel: out_strobe is high for one cycle with out_res;
// the receiver cannot stall it. Exactly one result follows each request.
// Config channel: cfg_data is the text colour, written when cfg_valid and
// cfg_ready are both high; cfg_ready is always high.
// Handling of each request from acceptance to its result:
//   carriage return, plain line feed, out-of-range cell request: answered from the idle state
//   put character, write cell: index build, then the cell write
//   read cell: index build, read issue, then the data from the registered read port
//   clear screen: one cell per cycle
//   line feed on the last row: each cell read and then written one row up,
//   then the bottom row fill.
// Reset: a clearing pass writes blanks in colour 7 to every cell; busy stays
// high through it, config writes are still taken, and it produces no result.
module text_console_cursor_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire tcw_pkg::in_req_t in_req,
  output logic                  out_strobe,
  output tcw_pkg::out_res_t     out_res,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [7:0]    text_color_r;
  logic [7:0]    text_color_nxt;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // Text colour register
  assign cfg_ready      = 1'b1;
  assign text_color_nxt = (cfg_valid && cfg_ready) ? cfg_data : text_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcw_pkg::RESET_COLOR;
    end else begin
      text_color_r <= text_color_nxt;
    end
  end

  tcw_seq #(
    .COLS (COLS),
    .ROWS (ROWS),
    .AW   (AW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_req     (in_req),
    .text_color (text_color_r),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_res    (out_res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
